// ===== src/rmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmd_pkg: shared types, constants and round functions
// Item formats, initial chaining words and per-step tables of the RIPEMD-160
// compression.
// ----------------------------------------------------------------------------
package rmd_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} lane_t;

	localparam int BlockWords = 16;
	localparam int StepCount  = 80;

	localparam logic [31:0] IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

	localparam logic [31:0] KL [5] = '{
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
	localparam logic [31:0] KR [5] = '{
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

	localparam logic [3:0] SEL_L [80] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
		4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
		4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
		4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
		4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
		4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
		4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

	localparam logic [3:0] SEL_R [80] = '{
		4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
		4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
		4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
		4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
		4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
		4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
		4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
		4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
		4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
		4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

	localparam logic [4:0] ROT_L [80] = '{
		5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
		5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
		5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
		5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
		5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
		5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
		5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
		5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
		5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
		5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6};

	localparam logic [4:0] ROT_R [80] = '{
		5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
		5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
		5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
		5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
		5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
		5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
		5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
		5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
		5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
		5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11};

	// Rotate left by 0..31
	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] w;
		w = {x, x} << n;
		return w[63:32];
	endfunction

	// Boolean mixing function of round group g
	function automatic logic [31:0] mix(input logic [2:0] g, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] r;
		unique case (g)
			3'd0: r = x ^ y ^ z;
			3'd1: r = (x & y) | (~x & z);
			3'd2: r = (x | ~y) ^ z;
			3'd3: r = (x & z) | (y & ~z);
			default: r = x ^ (y | ~z);
		endcase
		return r;
	endfunction

endpackage

// ===== src/rmd_ram.sv =====
// ----------------------------------------------------------------------------
// rmd_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmd_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_a,
	output logic [Width-1:0]         rdata_b
);
	logic [Width-1:0] mem_q [Depth];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

// ===== src/rmd_step.sv =====
// ----------------------------------------------------------------------------
// rmd_step: one compression step
// Advances the left and right lines by one of the 80 steps.
// ----------------------------------------------------------------------------
module rmd_step import rmd_pkg::*; (
	input  logic [6:0]  step,
	input  lane_t       lft,
	input  lane_t       rgt,
	input  logic [31:0] xl,
	input  logic [31:0] xr,
	output lane_t       lft_nxt,
	output lane_t       rgt_nxt
);
	logic [2:0]  grp;
	logic [2:0]  grp_r;
	logic [31:0] tl;
	logic [31:0] tr;

	assign grp   = step[6:4];
	assign grp_r = 3'd4 - grp;

	// Left and right line sums
	assign tl = rotl(lft.a + mix(grp, lft.b, lft.c, lft.d) + xl + KL[grp], ROT_L[step])
		+ lft.e;
	assign tr = rotl(rgt.a + mix(grp_r, rgt.b, rgt.c, rgt.d) + xr + KR[grp], ROT_R[step])
		+ rgt.e;

	// Shift the working words
	assign lft_nxt = '{a: lft.e, b: tl, c: lft.b, d: rotl(lft.c, 5'd10), e: lft.d};
	assign rgt_nxt = '{a: rgt.e, b: tr, c: rgt.b, d: rotl(rgt.c, 5'd10), e: rgt.d};
endmodule

// ===== src/ripemd160_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ripemd160_hash_engine_unit: streaming RIPEMD-160 hasher
// Byte packer, block RAM and an 80-step sequenced compression unit.
// ----------------------------------------------------------------------------
// Each item is packed into the block buffer one byte per cycle, except while
// a full block is compressed; input is not ready until the item is packed and
// the unit has returned to idle. Every completed 64-byte block takes a RAM
// prefetch, 80 steps through the single shared step unit and a chaining
// update. The last item further feeds 9 to 72 padding and length bytes one
// per cycle (again held while a block is compressed), passes through the
// padding, zero and length phases and compresses one or two more blocks. It
// then presents the five digest words, one per accepted cycle.
module ripemd160_hash_engine_unit import rmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FEED = 3'd1;
	localparam logic [2:0] S_COMP = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam logic [1:0] PH_MSG = 2'd0;
	localparam logic [1:0] PH_PAD = 2'd1;
	localparam logic [1:0] PH_ZER = 2'd2;
	localparam logic [1:0] PH_LEN = 2'd3;

	logic [2:0]  st_q;
	logic [1:0]  ph_q;
	logic [31:0] dat_q;
	logic [2:0]  rem_q;
	logic        last_q;
	logic [63:0] len_q;
	logic [3:0]  lenc_q;
	logic [5:0]  pos_q;
	logic [31:0] acc_q;
	logic [60:0] msg_q;
	logic [31:0] cv_q [5];
	lane_t       wl_q;
	lane_t       wr_q;
	logic [6:0]  cnt_q;
	logic [2:0]  oi_q;

	logic        put;
	logic [7:0]  pbyte;
	logic [31:0] acc_nxt;
	logic [6:0]  ridx;
	logic [31:0] xl;
	logic [31:0] xr;
	lane_t       nl;
	lane_t       nr;

	// Pick the byte to append this cycle
	always_comb begin
		put   = 1'b0;
		pbyte = dat_q[7:0];
		if (st_q == S_FEED) begin
			unique case (ph_q)
				PH_MSG: begin
					put   = rem_q != 3'd0;
					pbyte = dat_q[7:0];
				end
				PH_PAD: begin
					put   = 1'b1;
					pbyte = 8'h80;
				end
				PH_ZER: begin
					put   = pos_q != 6'd56;
					pbyte = 8'h00;
				end
				default: begin
					put   = lenc_q != 4'd8;
					pbyte = len_q[7:0];
				end
			endcase
		end
	end

	// Merge the byte into its lane
	always_comb begin
		acc_nxt = acc_q;
		acc_nxt[{pos_q[1:0], 3'b000} +: 8] = pbyte;
	end

	assign ridx = (cnt_q >= 7'(StepCount)) ? 7'd0 : cnt_q;

	rmd_ram #(.Width(32), .Depth(BlockWords)) u_ram (
		.clk     (clk),
		.we      (put && pos_q[1:0] == 2'd3),
		.waddr   (pos_q[5:2]),
		.wdata   (acc_nxt),
		.raddr_a (SEL_L[ridx]),
		.raddr_b (SEL_R[ridx]),
		.rdata_a (xl),
		.rdata_b (xr)
	);

	rmd_step u_step (
		.step    (cnt_q - 7'd1),
		.lft     (wl_q),
		.rgt     (wr_q),
		.xl      (xl),
		.xr      (xr),
		.lft_nxt (nl),
		.rgt_nxt (nr)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ph_q   <= PH_MSG;
			dat_q  <= '0;
			rem_q  <= '0;
			last_q <= 1'b0;
			len_q  <= '0;
			lenc_q <= '0;
			acc_q  <= '0;
			wl_q   <= '0;
			wr_q   <= '0;
			pos_q  <= '0;
			msg_q  <= '0;
			oi_q   <= '0;
			cnt_q  <= '0;
			for (int i = 0; i < 5; i++) begin
				cv_q[i] <= IV[i];
			end
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						dat_q  <= req.data_word;
						rem_q  <= (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
						last_q <= req.end_of_message;
						ph_q   <= PH_MSG;
						st_q   <= S_FEED;
					end
				end
				S_FEED: begin
					if (put) begin
						acc_q <= acc_nxt;
						pos_q <= pos_q + 6'd1;
						unique case (ph_q)
							PH_MSG: begin
								dat_q <= dat_q >> 8;
								rem_q <= rem_q - 3'd1;
								msg_q <= msg_q + 61'd1;
							end
							PH_PAD: ph_q <= PH_ZER;
							PH_ZER: ph_q <= PH_ZER;
							default: begin
								len_q  <= len_q >> 8;
								lenc_q <= lenc_q + 4'd1;
							end
						endcase
						// Block full: start compression
						if (pos_q == 6'd63) begin
							st_q  <= S_COMP;
							cnt_q <= '0;
							wl_q  <= '{a: cv_q[0], b: cv_q[1], c: cv_q[2], d: cv_q[3],
								e: cv_q[4]};
							wr_q  <= '{a: cv_q[0], b: cv_q[1], c: cv_q[2], d: cv_q[3],
								e: cv_q[4]};
						end
					end else begin
						unique case (ph_q)
							PH_MSG: begin
								if (last_q) begin
									ph_q  <= PH_PAD;
									len_q <= {msg_q, 3'b000};
								end else begin
									st_q <= S_IDLE;
								end
							end
							PH_ZER: begin
								ph_q   <= PH_LEN;
								lenc_q <= '0;
							end
							PH_PAD: ph_q <= PH_ZER;
							default: begin
								st_q <= S_OUT;
								oi_q <= '0;
							end
						endcase
					end
				end
				S_COMP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != 7'd0) begin
						wl_q <= nl;
						wr_q <= nr;
					end
					if (cnt_q == 7'(StepCount)) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					cv_q[0] <= cv_q[1] + wl_q.c + wr_q.d;
					cv_q[1] <= cv_q[2] + wl_q.d + wr_q.e;
					cv_q[2] <= cv_q[3] + wl_q.e + wr_q.a;
					cv_q[3] <= cv_q[4] + wl_q.a + wr_q.b;
					cv_q[4] <= cv_q[0] + wl_q.b + wr_q.c;
					st_q    <= S_FEED;
				end
				default: begin
					// Deliver digest words, then restart
					if (rsp_ready) begin
						if (oi_q == 3'd4) begin
							for (int i = 0; i < 5; i++) begin
								cv_q[i] <= IV[i];
							end
							msg_q <= '0;
							pos_q <= '0;
							st_q  <= S_IDLE;
						end else begin
							oi_q <= oi_q + 3'd1;
						end
					end
				end
			endcase
		end
	end

	assign req_ready       = st_q == S_IDLE;
	assign rsp_valid       = st_q == S_OUT;
	assign rsp.digest_word = cv_q[(oi_q > 3'd4) ? 3'd4 : oi_q];
	assign rsp.word_index  = oi_q;
	assign rsp.final_word  = oi_q == 3'd4;
endmodule

// ===== src/rmd_checker.sv =====
// ----------------------------------------------------------------------------
// rmd_checker: port-level assertions
// Checks digest delivery order and the handshake as seen at the ports.
// ----------------------------------------------------------------------------
module rmd_checker import rmd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input in_item_t  req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp
);
	// Hold a stalled digest item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("digest item changed while stalled");

	// Never take input while delivering digest
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("input ready during digest output");

	// Advance the word index by one
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.final_word
		|=> rsp_valid && rsp.word_index == $past(rsp.word_index) + 3'd1)
		else $error("digest words out of order");

	// Drop output after the final word
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.final_word |=> !rsp_valid)
		else $error("output after final digest word");

	// Give no result for a non-final item
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req.end_of_message |=> !rsp_valid)
		else $error("result after non-final item");
endmodule

bind ripemd160_hash_engine_unit rmd_checker u_rmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
